### hdl/rgbxy_pkg.sv
// Shared widths, matrix coefficients and the sRGB linearisation table.
package rgbxy_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CODE_W    = 8;
	localparam int LIN_W     = 25;
	localparam int COEF_W    = 20;
	localparam int PROD_W    = LIN_W + COEF_W;
	localparam int SUM_W     = 46;
	localparam int NSTEP     = FRAC_BITS + 1;
	localparam int Q_W       = FRAC_BITS + 2;
	localparam int NCODE     = 2 ** CODE_W;

	// matrix in millionths
	localparam logic [COEF_W-1:0] CXR = COEF_W'(664511);
	localparam logic [COEF_W-1:0] CXG = COEF_W'(154324);
	localparam logic [COEF_W-1:0] CXB = COEF_W'(162028);
	localparam logic [COEF_W-1:0] CYR = COEF_W'(283881);
	localparam logic [COEF_W-1:0] CYG = COEF_W'(668433);
	localparam logic [COEF_W-1:0] CYB = COEF_W'(47685);
	localparam logic [COEF_W-1:0] CZR = COEF_W'(88);
	localparam logic [COEF_W-1:0] CZG = COEF_W'(72310);
	localparam logic [COEF_W-1:0] CZB = COEF_W'(986039);

	localparam logic [63:0] Q30_ONE  = 64'd1073741824;
	localparam logic [63:0] Q30_HALF = 64'd536870912;

	typedef logic [NCODE-1:0][LIN_W-1:0] lin_tab_t;

	typedef struct packed {
		logic [LIN_W-1:0] r;
		logic [LIN_W-1:0] g;
		logic [LIN_W-1:0] b;
	} lin_t;

	typedef struct packed {
		logic [SUM_W-1:0] x;
		logic [SUM_W-1:0] y;
		logic [SUM_W-1:0] s;
	} sum_t;

	function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + Q30_HALF) >> 30;
	endfunction

	function automatic logic [63:0] q30_pow5(input logic [63:0] a);
		logic [63:0] a2;
		logic [63:0] a4;
		a2 = q30_mul(a, a);
		a4 = q30_mul(a2, a2);
		return q30_mul(a4, a);
	endfunction

	// evaluated at elaboration only, to fill the table
	function automatic logic [LIN_W-1:0] lin_code(input logic [63:0] c);
		logic [63:0] v;
		logic [63:0] w;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] l;
		int i;
		if (c * 64'd100000 <= 64'd1031475)
			return LIN_W'((((c * 64'd100) << 24) + 64'd164730) / 64'd329460);
		v = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
		if (v > Q30_ONE)
			v = Q30_ONE;
		w = q30_mul(v, v);
		lo = 64'd0;
		hi = Q30_ONE;
		// largest r with r^5 <= w, i.e. the 2.4 power via w^(1/5)
		for (i = 0; i < 32; i++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (q30_pow5(mid) <= w)
					lo = mid;
				else
					hi = mid - 64'd1;
			end
		end
		l = q30_mul(w, lo);
		return LIN_W'((l + 64'd32) >> 6);
	endfunction

	function automatic lin_tab_t build_lin_table();
		lin_tab_t t;
		int c;
		for (c = 0; c < NCODE; c++)
			t[c] = lin_code(64'(c));
		return t;
	endfunction

	localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

### hdl/rgbxy_if.sv
// Pixel and chromaticity channel interfaces.
interface rgbxy_pix_if;
	import rgbxy_pkg::*;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] red;
	logic [CODE_W-1:0] green;
	logic [CODE_W-1:0] blue;
	modport source(output valid, output red, output green, output blue, input ready);
	modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface rgbxy_chroma_if;
	import rgbxy_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS-1:0] chroma_x;
	logic [FRAC_BITS-1:0] chroma_y;
	logic                 is_black;
	modport source(output valid, output chroma_x, output chroma_y, output is_black,
		input ready);
	modport sink(input valid, input chroma_x, input chroma_y, input is_black,
		output ready);
endinterface

### hdl/rgbxy_lin.sv
// Linearisation stage: table lookup of the three channel codes.
module rgbxy_lin (
	input  logic                 clk,
	input  logic                 arst_n,
	rgbxy_pix_if.sink            pixel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rgbxy_pkg::lin_t      out_lin
);
	import rgbxy_pkg::*;

	logic v_s1;
	logic ld_s1;
	lin_t lin_s1;

	assign ld_s1       = !v_s1 || out_ready;
	assign pixel.ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			lin_s1.r <= LIN_TABLE[pixel.red];
			lin_s1.g <= LIN_TABLE[pixel.green];
			lin_s1.b <= LIN_TABLE[pixel.blue];
		end
	end

	assign out_valid = v_s1;
	assign out_lin   = lin_s1;

endmodule

### hdl/rgbxy_mix.sv
// Colour matrix: products, row sums, then X+Y+Z.
module rgbxy_mix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rgbxy_pkg::lin_t      in_lin,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rgbxy_pkg::sum_t      out_sum
);
	import rgbxy_pkg::*;

	logic              v_s1, v_s2, v_s3;
	logic              ld_s1, ld_s2, ld_s3;
	logic [PROD_W-1:0] px_s1 [3];
	logic [PROD_W-1:0] py_s1 [3];
	logic [PROD_W-1:0] pz_s1 [3];
	logic [SUM_W-1:0]  x_s2, y_s2, z_s2;
	sum_t              sum_s3;

	assign ld_s3    = !v_s3 || out_ready;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld_s1)
				v_s1 <= in_valid;
			if (ld_s2)
				v_s2 <= v_s1;
			if (ld_s3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			px_s1[0] <= PROD_W'(in_lin.r) * PROD_W'(CXR);
			px_s1[1] <= PROD_W'(in_lin.g) * PROD_W'(CXG);
			px_s1[2] <= PROD_W'(in_lin.b) * PROD_W'(CXB);
			py_s1[0] <= PROD_W'(in_lin.r) * PROD_W'(CYR);
			py_s1[1] <= PROD_W'(in_lin.g) * PROD_W'(CYG);
			py_s1[2] <= PROD_W'(in_lin.b) * PROD_W'(CYB);
			pz_s1[0] <= PROD_W'(in_lin.r) * PROD_W'(CZR);
			pz_s1[1] <= PROD_W'(in_lin.g) * PROD_W'(CZG);
			pz_s1[2] <= PROD_W'(in_lin.b) * PROD_W'(CZB);
		end
		if (ld_s2) begin
			x_s2 <= SUM_W'(px_s1[0]) + SUM_W'(px_s1[1]) + SUM_W'(px_s1[2]);
			y_s2 <= SUM_W'(py_s1[0]) + SUM_W'(py_s1[1]) + SUM_W'(py_s1[2]);
			z_s2 <= SUM_W'(pz_s1[0]) + SUM_W'(pz_s1[1]) + SUM_W'(pz_s1[2]);
		end
		if (ld_s3) begin
			sum_s3.x <= x_s2;
			sum_s3.y <= y_s2;
			sum_s3.s <= x_s2 + y_s2 + z_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_sum   = sum_s3;

endmodule

### hdl/rgbxy_div.sv
// Pipelined restoring divider for x = X/S and y = Y/S, one quotient bit per stage.
module rgbxy_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rgbxy_pkg::sum_t      in_sum,
	rgbxy_chroma_if.source       chroma
);
	import rgbxy_pkg::*;

	localparam logic [Q_W-1:0]       MAXQ = Q_W'(2 ** FRAC_BITS - 1);
	localparam logic [FRAC_BITS-1:0] MAXV = FRAC_BITS'(2 ** FRAC_BITS - 1);

	logic             v_s   [NSTEP+1];
	logic             ld_s  [NSTEP+1];
	logic [SUM_W-1:0] rx_s  [NSTEP+1];
	logic [SUM_W-1:0] ry_s  [NSTEP+1];
	logic [SUM_W-1:0] den_s [NSTEP+1];
	logic [Q_W-1:0]   qx_s  [NSTEP+1];
	logic [Q_W-1:0]   qy_s  [NSTEP+1];
	logic             satx_s[NSTEP+1];
	logic             saty_s[NSTEP+1];
	logic             blk_s [NSTEP+1];

	logic                 v_sf;
	logic                 ld_sf;
	logic [FRAC_BITS-1:0] cx_sf, cy_sf;
	logic                 blk_sf;

	logic [SUM_W:0]   dx0, dy0;
	logic             gex0, gey0;
	logic [Q_W:0]     rndx, rndy;
	logic [Q_W-1:0]   qxr, qyr;
	logic             satx, saty;

	// handshake chain: a stage loads when empty or when the next one loads
	assign ld_sf = !v_sf || chroma.ready;
	assign ld_s[NSTEP] = !v_s[NSTEP] || ld_sf;
	for (genvar k = 0; k < NSTEP; k++) begin : g_ld
		assign ld_s[k] = !v_s[k] || ld_s[k+1];
	end
	assign in_ready = ld_s[0];

	// integer part: a quotient of one or more is only possible when S = X alone
	assign dx0  = {1'b0, in_sum.x} - {1'b0, in_sum.s};
	assign dy0  = {1'b0, in_sum.y} - {1'b0, in_sum.s};
	assign gex0 = !dx0[SUM_W];
	assign gey0 = !dy0[SUM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (ld_s[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s[0]) begin
			rx_s[0]   <= gex0 ? dx0[SUM_W-1:0] : in_sum.x;
			ry_s[0]   <= gey0 ? dy0[SUM_W-1:0] : in_sum.y;
			qx_s[0]   <= Q_W'(gex0);
			qy_s[0]   <= Q_W'(gey0);
			satx_s[0] <= gex0 && (dx0[SUM_W-1:0] >= in_sum.s);
			saty_s[0] <= gey0 && (dy0[SUM_W-1:0] >= in_sum.s);
			den_s[0]  <= in_sum.s;
			blk_s[0]  <= (in_sum.s == '0);
		end
	end

	for (genvar k = 1; k <= NSTEP; k++) begin : g_step
		logic [SUM_W:0]   shx, shy;
		logic [SUM_W+1:0] dfx, dfy;
		logic             gex, gey;

		assign shx = {rx_s[k-1], 1'b0};
		assign shy = {ry_s[k-1], 1'b0};
		assign dfx = {1'b0, shx} - {2'b00, den_s[k-1]};
		assign dfy = {1'b0, shy} - {2'b00, den_s[k-1]};
		assign gex = !dfx[SUM_W+1];
		assign gey = !dfy[SUM_W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (ld_s[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ld_s[k]) begin
				rx_s[k]   <= gex ? dfx[SUM_W-1:0] : shx[SUM_W-1:0];
				ry_s[k]   <= gey ? dfy[SUM_W-1:0] : shy[SUM_W-1:0];
				qx_s[k]   <= {qx_s[k-1][Q_W-2:0], gex};
				qy_s[k]   <= {qy_s[k-1][Q_W-2:0], gey};
				satx_s[k] <= satx_s[k-1];
				saty_s[k] <= saty_s[k-1];
				den_s[k]  <= den_s[k-1];
				blk_s[k]  <= blk_s[k-1];
			end
		end
	end

	// half-up rounding of the extra quotient bit, then saturation
	assign rndx = {1'b0, qx_s[NSTEP]} + (Q_W+1)'(1);
	assign rndy = {1'b0, qy_s[NSTEP]} + (Q_W+1)'(1);
	assign qxr  = rndx[Q_W:1];
	assign qyr  = rndy[Q_W:1];
	assign satx = satx_s[NSTEP] || (qxr > MAXQ);
	assign saty = saty_s[NSTEP] || (qyr > MAXQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (ld_sf) begin
			v_sf <= v_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_sf) begin
			blk_sf <= blk_s[NSTEP];
			if (blk_s[NSTEP]) begin
				cx_sf <= '0;
				cy_sf <= '0;
			end else begin
				cx_sf <= satx ? MAXV : qxr[FRAC_BITS-1:0];
				cy_sf <= saty ? MAXV : qyr[FRAC_BITS-1:0];
			end
		end
	end

	assign chroma.valid    = v_sf;
	assign chroma.chroma_x = cx_sf;
	assign chroma.chroma_y = cy_sf;
	assign chroma.is_black = blk_sf;

endmodule

### hdl/rgb_to_xy_chromaticity_core.sv
// Top level: sRGB pixel to CIE xy chromaticity pipeline.
//
// pixel (sink): one 8-bit red, green, blue item per handshake (valid && ready).
// chroma (source): chroma_x and chroma_y as unsigned fractions with FRAC_BITS
//   fraction bits, and is_black, set with both fractions zero when X+Y+Z is 0.
// Every pixel gives exactly one result, in order.
// From accept to valid result an item passes through the registered table
//   lookup, the matrix stages (products, row sums, total) and the divider
//   stages (integer step, one quotient bit per stage, rounding into the
//   output register).
// Throughput: one item per cycle while the output is not stalled; the divider
//   stages, one subtract and compare on a 46-bit remainder each, set the clock.
// Each stage holds its item while the next is full; ready runs back through
//   the stages, so empty stages keep filling while a result waits at the
//   output. Nothing is lost or repeated across a stall.
// Reset clears all valid bits; the pipeline is empty and ready at once.
module rgb_to_xy_chromaticity_core (
	input  logic           clk,
	input  logic           arst_n,
	rgbxy_pix_if.sink      pixel,
	rgbxy_chroma_if.source chroma
);
	import rgbxy_pkg::*;

	logic lin_valid, lin_ready;
	lin_t lin_data;
	logic mix_valid, mix_ready;
	sum_t mix_sum;

	rgbxy_lin u_lin (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.out_valid (lin_valid),
		.out_ready (lin_ready),
		.out_lin   (lin_data)
	);

	rgbxy_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lin_valid),
		.in_ready  (lin_ready),
		.in_lin    (lin_data),
		.out_valid (mix_valid),
		.out_ready (mix_ready),
		.out_sum   (mix_sum)
	);

	rgbxy_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mix_valid),
		.in_ready (mix_ready),
		.in_sum   (mix_sum),
		.chroma   (chroma)
	);

`ifndef SYNTH
	// a black result carries zero chromaticity
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		chroma.valid && chroma.is_black |-> chroma.chroma_x == '0 && chroma.chroma_y == '0)
		else $error("black item with nonzero chromaticity");

	// x + y cannot exceed one by more than a single ulp of rounding
	a_xy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chroma.valid && !chroma.is_black |->
		({1'b0, chroma.chroma_x} + {1'b0, chroma.chroma_y}) <=
		(FRAC_BITS+1)'(2 ** FRAC_BITS + 1))
		else $error("chromaticity x + y out of range");

	// a free output lets every stage advance, so the input must be open
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		chroma.ready |-> pixel.ready)
		else $error("input stalled while output is free");
`endif

endmodule
